@@ sv/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame classifier package
// Shared constants, codes, types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   localparam int MAX_FRAME_BYTES = 255;
   localparam int COUNT_W         = 9;
   localparam int HDR_BYTES       = 7;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FUNC_READ_INPUT    = 8'h04;
   localparam logic [7:0] FUNC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FUNC_WRITE_MULTI   = 8'h10;

   localparam logic [7:0] BROADCAST_RESET = 8'd9;

   typedef enum logic [2:0] {
      KIND_INVALID   = 3'd0,
      KIND_REQUEST   = 3'd1,
      KIND_RESPONSE  = 3'd2,
      KIND_EXCEPTION = 3'd3,
      KIND_ECHO      = 3'd4
   } kind_type;

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_NOTE    = 1'b1
   } op_type;

   typedef logic [HDR_BYTES-1:0][7:0] header_type;

   typedef struct packed {
      logic [7:0]  address;
      logic [7:0]  func;
      logic [15:0] register;
   } pending_type;

   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [7:0]  device_address;
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [15:0] register_count;
      logic [15:0] write_value;
      logic [7:0]  data_length;
      logic [7:0]  exception_code;
      logic [7:0]  data_offset;
   } result_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc_cur,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc_cur ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ sv/mbrtu_classify.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame decode
// Checks CRC and length of a finished frame, classifies it, extracts its
// fields and computes the next tracked outstanding request.
// ----------------------------------------------------------------------------
module mbrtu_classify (
   input  mbrtu_pkg::header_type              header,
   input  logic [mbrtu_pkg::COUNT_W-1:0]      frame_len,
   input  logic [15:0]                        crc,
   input  logic [7:0]                         broadcast_address,
   input  mbrtu_pkg::pending_type             pending_cur,
   output mbrtu_pkg::pending_type             pending_next,
   output mbrtu_pkg::result_type              result
);
   import mbrtu_pkg::*;

   kind_type    kind;
   logic [7:0]  addr;
   logic [7:0]  func;
   logic [15:0] reg_addr;
   logic [15:0] cnt;
   logic [15:0] val;
   logic [7:0]  dlen;
   logic [7:0]  exc;
   logic [7:0]  doff;
   logic [7:0]  body_len;
   logic        frame_ok;
   logic        is_read;

   assign body_len = frame_len[7:0] - 8'd2;
   assign frame_ok = (frame_len > COUNT_W'(4)) && (frame_len <= COUNT_W'(MAX_FRAME_BYTES))
                     && (crc == 16'h0000);

   always_comb begin
      kind         = KIND_INVALID;
      addr         = '0;
      func         = '0;
      reg_addr     = '0;
      cnt          = '0;
      val          = '0;
      dlen         = '0;
      exc          = '0;
      doff         = '0;
      is_read      = 1'b0;
      pending_next = pending_cur;
      if (frame_ok) begin
         if (body_len == 8'd3) begin
            kind = KIND_EXCEPTION;
            addr = header[0];
            func = header[1];
            exc  = header[2];
         end else if (body_len >= 8'd5) begin
            addr    = header[0];
            func    = header[1];
            is_read = (func == FUNC_READ_HOLDING) || (func == FUNC_READ_INPUT);
            if (is_read) begin
               if (body_len == 8'd6) begin
                  kind     = KIND_REQUEST;
                  reg_addr = {header[2], header[3]};
                  cnt      = {header[4], header[5]};
               end else begin
                  dlen = header[2];
                  if (dlen == body_len - 8'd3) begin
                     kind = KIND_RESPONSE;
                  end
               end
            end else if (func == FUNC_WRITE_SINGLE) begin
               if (body_len == 8'd6) begin
                  kind     = KIND_ECHO;
                  reg_addr = {header[2], header[3]};
                  cnt      = 16'd1;
                  val      = {header[4], header[5]};
               end
            end else if (func == FUNC_WRITE_MULTI) begin
               reg_addr = {header[2], header[3]};
               cnt      = {header[4], header[5]};
               if (body_len == 8'd6) begin
                  kind = KIND_RESPONSE;
               end else begin
                  dlen = header[6];
                  if (body_len >= 8'd7 && dlen == body_len - 8'd7) begin
                     kind = KIND_REQUEST;
                  end
               end
            end

            if (kind != KIND_INVALID && dlen != 8'd0) begin
               doff = body_len - dlen;
            end

            unique case (kind)
               KIND_REQUEST: begin
                  pending_next = '{address: addr, func: func, register: reg_addr};
               end
               KIND_RESPONSE: begin
                  if (addr == pending_cur.address && func == pending_cur.func && is_read) begin
                     reg_addr = pending_cur.register;
                  end
                  pending_next = '0;
               end
               KIND_ECHO: begin
                  if (addr == pending_cur.address && func == pending_cur.func &&
                      addr != broadcast_address) begin
                     kind         = KIND_RESPONSE;
                     pending_next = '0;
                  end else begin
                     kind         = KIND_REQUEST;
                     pending_next = '{address: addr, func: func, register: reg_addr};
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign result = '{frame_kind:       kind[1:0],
                     device_address:   addr,
                     function_code:    func,
                     register_address: reg_addr,
                     register_count:   cnt,
                     write_value:      val,
                     data_length:      dlen,
                     exception_code:   exc,
                     data_offset:      doff};

endmodule

@@ sv/modbus_rtu_frame_classifier.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame classifier
// Takes frame bytes one per item, keeps a running CRC-16 and the frame
// header, and delivers one classified result item for each final byte.
//
//   Channel  Direction  Contents
//   req_     in         operation, data byte, last-byte mark, noted request
//   rsp_     out        frame kind and decoded fields, one per final byte
//   csr_     in         broadcast address write
//
// An item is taken into an input register, processed there and its result
// lands in an output register; one item per cycle unless a stalled result
// holds the input register, which it does only while that item itself has
// a result to deliver. Reset clears the byte count, header and tracked
// request, sets the CRC to FFFF and the broadcast address to 9.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [7:0]  req_sent_address,
   input  logic [7:0]  req_sent_function,
   input  logic [15:0] req_sent_register,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_kind,
   output logic [7:0]  rsp_device_address,
   output logic [7:0]  rsp_function_code,
   output logic [15:0] rsp_register_address,
   output logic [15:0] rsp_register_count,
   output logic [15:0] rsp_write_value,
   output logic [7:0]  rsp_data_length,
   output logic [7:0]  rsp_exception_code,
   output logic [7:0]  rsp_data_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import mbrtu_pkg::*;

   logic               in_valid_ff,  in_valid_in;
   logic               in_op_ff;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   pending_type        in_sent_ff;

   logic [COUNT_W-1:0] count_ff,     count_in;
   logic [15:0]        crc_ff,       crc_in;
   header_type         header_ff,    header_in;
   pending_type        pending_ff,   pending_in;
   logic [7:0]         bcast_ff;

   logic               out_valid_ff, out_valid_in;
   result_type         out_ff;

   logic               has_result;
   logic               advance;
   logic [COUNT_W-1:0] count_inc;
   logic [15:0]        crc_upd;
   pending_type        pending_dec;
   result_type         result;

   assign has_result   = in_valid_ff && (in_op_ff == OP_RECEIVE) && in_last_ff;
   assign advance      = in_valid_ff && (!has_result || !out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = (advance && has_result) || (out_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   assign count_inc = (count_ff < COUNT_W'(MAX_FRAME_BYTES + 1)) ? count_ff + 1'b1 : count_ff;
   assign crc_upd   = crc_update(crc_ff, in_byte_ff);

   always_comb begin
      header_in = header_ff;
      for (int i = 0; i < HDR_BYTES; i++) begin
         if (count_ff == COUNT_W'(i)) begin
            header_in[i] = in_byte_ff;
         end
      end
   end

   mbrtu_classify u_classify (
      .header            (header_in),
      .frame_len         (count_inc),
      .crc               (crc_upd),
      .broadcast_address (bcast_ff),
      .pending_cur       (pending_ff),
      .pending_next      (pending_dec),
      .result            (result)
   );

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      pending_in = pending_ff;
      if (in_op_ff == OP_NOTE) begin
         pending_in = in_sent_ff;
      end else if (in_last_ff) begin
         count_in   = '0;
         crc_in     = CRC_INIT;
         pending_in = pending_dec;
      end else begin
         count_in = count_inc;
         crc_in   = crc_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         header_ff    <= '0;
         pending_ff   <= '0;
         bcast_ff     <= BROADCAST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            count_ff   <= count_in;
            crc_ff     <= crc_in;
            pending_ff <= pending_in;
            if (in_op_ff == OP_RECEIVE) begin
               header_ff <= header_in;
            end
         end
         if (csr_valid && csr_ready) begin
            bcast_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
         in_sent_ff <= '{address:  req_sent_address,
                         func:     req_sent_function,
                         register: req_sent_register};
      end
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_frame_kind       = out_ff.frame_kind;
   assign rsp_device_address   = out_ff.device_address;
   assign rsp_function_code    = out_ff.function_code;
   assign rsp_register_address = out_ff.register_address;
   assign rsp_register_count   = out_ff.register_count;
   assign rsp_write_value      = out_ff.write_value;
   assign rsp_data_length      = out_ff.data_length;
   assign rsp_exception_code   = out_ff.exception_code;
   assign rsp_data_offset      = out_ff.data_offset;

endmodule
